FILE: hw/rtl/fcsa_pkg.sv
// Package for the fft centre-shift address block.
// Holds the item types, field widths and register index codes.
// No dependencies.
package fcsa_pkg;

    localparam int IDX_W   = 20;
    localparam int VAL_W   = 64;
    localparam int LEN_W   = 17;
    localparam int DIMS_W  = 3;
    localparam int NUM_LEN = 4;
    localparam int CFG_IDX_W = 3;

    // quotient bits resolved per divider stage
    localparam int BPS         = 4;
    localparam int STG_PER_DIM = IDX_W / BPS;

    localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM0_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM1_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM2_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM3_LENGTH = 3'd4;

    typedef struct packed {
        logic [IDX_W-1:0] flat_index;
        logic [VAL_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] dest_index;
        logic [VAL_W-1:0] moved_value;
        logic             in_range;
    } t_out_item;

    // effective lengths, unused dimensions read as 1
    typedef struct packed {
        logic [NUM_LEN-1:0][LEN_W-1:0] len;
    } t_shape;

endpackage

FILE: hw/rtl/fcsa_cfg_regs.sv
// Configuration registers of the fft centre-shift address block.
// Gives the effective dimension lengths as a shape struct.
// Depends on fcsa_pkg.
module fcsa_cfg_regs #(
    parameter int MAX_DIMS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fcsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fcsa_pkg::LEN_W-1:0]     i_cfg_data,
    output fcsa_pkg::t_shape               o_shape
);
    import fcsa_pkg::*;

    localparam int CAP = (MAX_DIMS < NUM_LEN) ? MAX_DIMS : NUM_LEN;

    logic [DIMS_W-1:0]             r_dims;
    logic [NUM_LEN-1:0][LEN_W-1:0] r_len;
    logic [DIMS_W-1:0]             n_act0;
    logic [DIMS_W-1:0]             n_act;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_W'(1);
            for (int d = 0; d < NUM_LEN; d++) begin
                r_len[d] <= LEN_W'(1);
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIMS_IN_USE: r_dims   <= i_cfg_data[DIMS_W-1:0];
                CFG_DIM0_LENGTH: r_len[0] <= i_cfg_data;
                CFG_DIM1_LENGTH: r_len[1] <= i_cfg_data;
                CFG_DIM2_LENGTH: r_len[2] <= i_cfg_data;
                CFG_DIM3_LENGTH: r_len[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_act0 = (r_dims == '0) ? DIMS_W'(1) : r_dims;
        n_act  = (n_act0 > DIMS_W'(CAP)) ? DIMS_W'(CAP) : n_act0;
        for (int d = 0; d < NUM_LEN; d++) begin
            o_shape.len[d] = (DIMS_W'(d) < n_act) ? r_len[d] : LEN_W'(1);
        end
    end

endmodule

FILE: hw/rtl/fft_center_shift_address.sv
// Top level of the fft centre-shift address block: pipelined index remap.
// Depends on fcsa_pkg and fcsa_cfg_regs.
//
// Takes one item per cycle and returns one item per cycle unless the output
// stalls. It holds the coordinate divider, 20 stages that each resolve four
// quotient bits (five per dimension, four dimensions), followed by four
// multiply-add stages that rebuild the row-major index.
// Every stage is a register with its own valid bit; empty stages close up
// under output stall, so input is taken while a result waits.
module fft_center_shift_address #(
    parameter int MAX_DIMS      = 4,
    parameter int MAX_ELEMENTS  = 1048576,
    parameter int ELEMENT_WIDTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  fcsa_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output fcsa_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fcsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fcsa_pkg::LEN_W-1:0]     i_cfg_data
);
    import fcsa_pkg::*;

    localparam int DW      = $clog2(MAX_ELEMENTS);
    localparam int PW      = $clog2(MAX_ELEMENTS + 1);
    localparam int MW      = PW + LEN_W;
    localparam int WC      = IDX_W + PW;
    localparam int DIV_STG = NUM_LEN * STG_PER_DIM;
    localparam int NSTG    = DIV_STG + NUM_LEN;
    localparam logic [MW-1:0] MAXV = MW'(MAX_ELEMENTS);

    typedef struct packed {
        logic [IDX_W-1:0]              flat;
        logic [IDX_W-1:0]              quo;
        logic [LEN_W:0]                rem;
        logic [NUM_LEN-1:0][LEN_W-1:0] coord;
        logic [PW-1:0]                 prod;
        logic                          big;
        logic                          ok;
        logic [DW-1:0]                 dest;
        logic [ELEMENT_WIDTH-1:0]      value;
    } t_stage;

    t_shape shape;
    t_stage in_st;
    t_stage src   [NSTG];
    t_stage n_st  [NSTG];
    t_stage r_st  [NSTG];
    logic   srcv  [NSTG];
    logic   r_v   [NSTG];
    logic   en    [NSTG+1];

    fcsa_cfg_regs #(
        .MAX_DIMS (MAX_DIMS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_shape     (shape)
    );

    always_comb begin
        in_st       = '0;
        in_st.flat  = i_in_item.flat_index;
        in_st.quo   = i_in_item.flat_index;
        in_st.value = ELEMENT_WIDTH'(i_in_item.element_value);
    end

    always_comb begin
        en[NSTG] = !i_out_stall;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_in_stall = !en[0];

    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_stg
            if (k == 0) begin : g_src0
                assign src[k]  = in_st;
                assign srcv[k] = i_in_valid;
            end else begin : g_srcn
                assign src[k]  = r_st[k-1];
                assign srcv[k] = r_v[k-1];
            end

            if (k < DIV_STG) begin : g_div
                localparam int DIM = NUM_LEN - 1 - k / STG_PER_DIM;
                localparam int PK  = (k < NUM_LEN - 1) ? k : 0;
                always_comb begin
                    t_stage            st;
                    logic [LEN_W-1:0]  l;
                    logic [MW-1:0]     p;
                    st = src[k];
                    l  = shape.len[DIM];
                    p  = '0;
                    if (k % STG_PER_DIM == 0) begin
                        st.rem = '0;
                    end
                    for (int j = 0; j < BPS; j++) begin
                        st.rem = {st.rem[LEN_W-1:0], st.quo[IDX_W-1]};
                        st.quo = {st.quo[IDX_W-2:0], 1'b0};
                        if (st.rem >= {1'b0, l}) begin
                            st.rem    = st.rem - {1'b0, l};
                            st.quo[0] = 1'b1;
                        end
                    end
                    if (k % STG_PER_DIM == STG_PER_DIM - 1) begin
                        st.coord[DIM] = st.rem[LEN_W-1:0];
                    end
                    if (k < NUM_LEN - 1) begin
                        if (k == 0) begin
                            p      = MW'(shape.len[0]) * MW'(shape.len[1]);
                            st.big = (MW'(shape.len[0]) > MAXV) || (p > MAXV);
                        end else begin
                            p      = MW'(st.prod) * MW'(shape.len[PK+1]);
                            st.big = st.big || (p > MAXV);
                        end
                        st.prod = PW'(p);
                    end
                    n_st[k] = st;
                end
            end else begin : g_hor
                localparam int HD = k - DIV_STG;
                always_comb begin
                    t_stage               st;
                    logic [LEN_W-1:0]     l;
                    logic [LEN_W:0]       c;
                    logic [DW+LEN_W-1:0]  m;
                    st = src[k];
                    l  = shape.len[HD];
                    if (HD == 0) begin
                        st.ok = !st.big && (WC'(st.flat) < WC'(st.prod));
                    end
                    c = {1'b0, st.coord[HD]} + {2'b0, l[LEN_W-1:1]};
                    if (c >= {1'b0, l}) begin
                        c = c - {1'b0, l};
                    end
                    m       = (DW+LEN_W)'(st.dest) * (DW+LEN_W)'(l);
                    st.dest = DW'(m + (DW+LEN_W)'(c));
                    n_st[k] = st;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (en[k]) begin
                    r_v[k] <= srcv[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_st[k] <= n_st[k];
                end
            end
        end
    endgenerate

    assign o_out_valid            = r_v[NSTG-1];
    assign o_out_item.in_range    = r_st[NSTG-1].ok;
    assign o_out_item.moved_value = VAL_W'(r_st[NSTG-1].value);
    assign o_out_item.dest_index  = r_st[NSTG-1].ok ? IDX_W'(r_st[NSTG-1].dest) : '0;

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.in_range |-> o_out_item.dest_index == '0)
        else $error("out-of-range item with nonzero destination");

    a_accept_fills_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_v[0])
        else $error("accepted item lost at first stage");

    a_last_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG-2] && !i_out_stall |=> o_out_valid)
        else $error("item lost before output stage");

endmodule

FILE: verif/fft_center_shift_address_tb.sv
// Testbench for fft_center_shift_address: streams indexed elements under random
// shapes, idling and output stall, and checks each remapped item in order.
// Depends on fcsa_pkg and the block's RTL.
module fft_center_shift_address_tb;
    import fcsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ELEMS = 1048576;
    localparam int LATENCY   = 24;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_DIMS_IN_USE;
    logic [LEN_W-1:0]     i_cfg_data = '0;

    fft_center_shift_address dut (.*);

    always #6 i_clk = ~i_clk;

    logic [DIMS_W-1:0] dims_reg;
    logic [LEN_W-1:0]  len_reg [NUM_LEN];
    t_out_item         remap_q [$];
    int                errors = 0;
    int                stall_mode = 0;

    function automatic t_out_item remap(t_in_item it);
        t_out_item r;
        int n;
        longint total, rem, dest, c, L;
        longint crd [NUM_LEN];
        bit too_big;
        n = (dims_reg == 0) ? 1 : (dims_reg > NUM_LEN ? NUM_LEN : int'(dims_reg));
        total = 1;
        too_big = 0;
        r.moved_value = it.element_value;
        for (int d = 0; d < n; d++) begin
            total = total * len_reg[d];
            if (total > MAX_ELEMS) begin
                too_big = 1;
                break;
            end
        end
        if (too_big || it.flat_index >= total) begin
            r.dest_index = '0;
            r.in_range = 1'b0;
            return r;
        end
        rem = it.flat_index;
        for (int d = n - 1; d >= 0; d--) begin
            crd[d] = rem % len_reg[d];
            rem = rem / len_reg[d];
        end
        dest = 0;
        for (int d = 0; d < n; d++) begin
            L = len_reg[d];
            c = (crd[d] + L / 2) % L;
            dest = dest * L + c;
        end
        r.dest_index = dest[IDX_W-1:0];
        r.in_range = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (remap_q.size() == 0) begin
                $error("unexpected item dest_index=%0d", o_out_item.dest_index);
                errors++;
            end else begin
                e = remap_q.pop_front();
                if (e.dest_index !== o_out_item.dest_index) begin
                    $error("dest_index exp %0d got %0d", e.dest_index, o_out_item.dest_index);
                    errors++;
                end
                if (e.moved_value !== o_out_item.moved_value) begin
                    $error("moved_value exp %h got %h", e.moved_value, o_out_item.moved_value);
                    errors++;
                end
                if (e.in_range !== o_out_item.in_range) begin
                    $error("in_range exp %0b got %0b", e.in_range, o_out_item.in_range);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_DIMS_IN_USE) dims_reg = data[DIMS_W-1:0];
        else if (idx <= CFG_DIM3_LENGTH) len_reg[idx - 1] = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (remap_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // keep_valid: leave valid high for a following item in the same burst
    task automatic send(t_in_item it, bit keep_valid, bit chk, t_out_item exp_r);
        t_out_item p;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        p = remap(it);
        if (chk && p !== exp_r) begin
            $error("directed row mismatch dest_index exp %0d got %0d",
                   exp_r.dest_index, p.dest_index);
            errors++;
        end
        remap_q.push_back(p);
        @(negedge i_clk);
        if (!keep_valid) i_in_valid <= 1'b0;
    endtask

    task automatic set_shape(int n, int l0, int l1, int l2, int l3);
        write_reg(CFG_DIMS_IN_USE, LEN_W'(n));
        write_reg(CFG_DIM0_LENGTH, LEN_W'(l0));
        write_reg(CFG_DIM1_LENGTH, LEN_W'(l1));
        write_reg(CFG_DIM2_LENGTH, LEN_W'(l2));
        write_reg(CFG_DIM3_LENGTH, LEN_W'(l3));
    endtask

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        bit               chk;
        logic [IDX_W-1:0] dst;
        logic             rng;
    } t_row;

    function automatic int shape_total();
        longint t = 1;
        int n = (dims_reg == 0) ? 1 : (dims_reg > NUM_LEN ? NUM_LEN : int'(dims_reg));
        for (int d = 0; d < n; d++) t = t * len_reg[d];
        return (t > MAX_ELEMS) ? MAX_ELEMS : int'(t);
    endfunction

    function automatic int rand_len(int cap);
        case ($urandom_range(0, 5))
            0: return 1;
            1: return 2;
            2: return cap;
            default: return $urandom_range(1, cap);
        endcase
    endfunction

    initial begin
        t_row rows [$];
        t_in_item it;
        t_out_item ex;
        int burst, tot;
        int lens [NUM_LEN];
        bit gap;
        dims_reg = 3'd1;
        for (int d = 0; d < NUM_LEN; d++) len_reg[d] = 17'd1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset shape 1: only index 0 in range
        rows = '{
            '{20'd0, 64'h0, 1, 20'd0, 1'b1},
            '{20'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 20'd0, 1'b0},
            '{20'hFFFFF, 64'hA5A5_5A5A_0F0F_F0F0, 1, 20'd0, 1'b0}
        };
        foreach (rows[i]) begin
            it.flat_index = rows[i].idx;
            it.element_value = rows[i].val;
            ex.dest_index = rows[i].dst;
            ex.moved_value = rows[i].val;
            ex.in_range = rows[i].rng;
            send(it, i != rows.size() - 1, rows[i].chk, ex);
        end
        drain();

        // 1-d length 8: shift by 4; 4-d; zero length; oversized; dims 0 and 7; max length
        set_shape(1, 8, 1, 1, 1);
        rows = '{
            '{20'd0, 64'h1, 1, 20'd4, 1'b1},
            '{20'd7, 64'h2, 1, 20'd3, 1'b1},
            '{20'd8, 64'h3, 1, 20'd0, 1'b0}
        };
        foreach (rows[i]) begin
            it.flat_index = rows[i].idx;
            it.element_value = rows[i].val;
            ex.dest_index = rows[i].dst;
            ex.moved_value = rows[i].val;
            ex.in_range = rows[i].rng;
            send(it, i != rows.size() - 1, rows[i].chk, ex);
        end
        drain();
        set_shape(4, 3, 5, 7, 9);
        for (int k = 0; k < 4; k++) begin
            it.flat_index = (k == 3) ? 20'd944 : IDX_W'($urandom_range(0, 945));
            it.element_value = {$urandom, $urandom};
            send(it, k != 3, 0, ex);
        end
        drain();
        set_shape(2, 4, 0, 1, 1);
        it.flat_index = 0; it.element_value = 64'h55;
        ex.dest_index = 0; ex.moved_value = 64'h55; ex.in_range = 0;
        send(it, 0, 1, ex);
        drain();
        set_shape(2, 65536, 65536, 1, 1);
        it.flat_index = 5; it.element_value = 64'hAA;
        ex.dest_index = 0; ex.moved_value = 64'hAA; ex.in_range = 0;
        send(it, 0, 1, ex);
        drain();
        set_shape(0, 16, 3, 3, 3);
        it.flat_index = 3; it.element_value = '1;
        send(it, 0, 0, ex);
        drain();
        set_shape(7, 2, 2, 2, 2);
        it.flat_index = 15; it.element_value = 0;
        send(it, 0, 0, ex);
        drain();
        set_shape(1, 65536, 1, 1, 1);
        it.flat_index = 20'd65535; it.element_value = 64'h7;
        ex.dest_index = 20'd32767; ex.moved_value = 64'h7; ex.in_range = 1;
        send(it, 0, 1, ex);
        drain();
        set_shape(2, 16, 65536, 1, 1);
        it.flat_index = 20'hFFFFF; it.element_value = 64'h9;
        send(it, 0, 0, ex);
        drain();

        // random phases
        for (int ph = 0; ph < 11; ph++) begin
            int n, cap;
            n = $urandom_range(0, 7);
            cap = (ph % 3 == 0) ? 65536 : 40;
            for (int d = 0; d < NUM_LEN; d++) lens[d] = rand_len(cap);
            if (ph == 5) lens[1] = 0;
            stall_mode = ph % 3;
            set_shape(n, lens[0], lens[1], lens[2], lens[3]);
            tot = shape_total();
            for (int k = 0; k < 100; ) begin
                burst = $urandom_range(1, 12);
                gap = ($urandom_range(0, 2) != 0);
                for (int b = 0; b < burst && k < 100; b++, k++) begin
                    if ($urandom_range(0, 9) == 0 || tot == 0)
                        it.flat_index = IDX_W'($urandom);
                    else
                        it.flat_index = IDX_W'($urandom_range(0, tot - 1));
                    it.element_value = {$urandom, $urandom};
                    send(it, (k != 99) && ((b != burst - 1) ||
                             (!gap && !(ph == 2 && k == 49))), 0, ex);
                end
                if (k == 50 && ph == 2) begin
                    while (remap_q.size() != 0) @(posedge i_clk);
                    @(negedge i_clk);
                end
                if (gap)
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            drain();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/fcsa_pkg.sv
hw/rtl/fcsa_cfg_regs.sv
hw/rtl/fft_center_shift_address.sv
verif/fft_center_shift_address_tb.sv
